// File: rtl/command_gated_block_capture_unit_defines.svh
// ----------------------------------------------------------------------------
// command_gated_block_capture_unit_defines
// assertion macros shared by the capture unit modules
// ----------------------------------------------------------------------------
`ifndef COMMAND_GATED_BLOCK_CAPTURE_UNIT_DEFINES_SVH
`define COMMAND_GATED_BLOCK_CAPTURE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define CGBC_ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("cgbc assertion failed");

// condition implies consequence in the next cycle
`define CGBC_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("cgbc assertion failed");

`else

`define CGBC_ASSERT_IMPL(label, clk, rst, cond, cons)
`define CGBC_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// File: rtl/cgbc_pkg.sv
// ----------------------------------------------------------------------------
// cgbc_pkg
// types and constants of the command gated block capture unit
// ----------------------------------------------------------------------------
package cgbc_pkg;

  // command codes on the control link
  localparam logic [7:0] CMD_NAME   = 8'hF3;
  localparam logic [7:0] CMD_STOP   = 8'hE2;
  localparam logic [7:0] CMD_START  = 8'hD3;
  localparam logic [7:0] CMD_TAG_LO = 8'hC1;
  localparam logic [7:0] CMD_TAG_HI = 8'hC4;
  localparam logic [7:0] NAME_END   = 8'h00;

  localparam int PAYLOAD_W = 10;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 10'd504;

  localparam int ADDR_W  = 14;
  localparam int RBLK_W  = 5;
  localparam int NIDX_W  = 4;
  localparam int TAG_W   = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_NAME,
    KIND_STOP,
    KIND_START,
    KIND_TAG,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [TAG_W-1:0] tag;
  } item_t;

  // first member sits in the top bits, so mem_write lands at bit 0
  typedef struct packed {
    logic [TAG_W-1:0]  tag_code;
    logic              stop_event;
    logic              start_event;
    logic              name_done;
    logic [NIDX_W-1:0] name_index;
    logic              name_write;
    logic [RBLK_W-1:0] ready_block;
    logic              block_ready;
    logic [7:0]        out_byte;
    logic [ADDR_W-1:0] mem_address;
    logic              mem_write;
  } result_t;

endpackage

// File: rtl/cgbc_front.sv
// ----------------------------------------------------------------------------
// cgbc_front
// input stage: takes bytes from the stream and decodes their kind
// ----------------------------------------------------------------------------
module cgbc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // byte_in
  input  logic              s_tuser,   // operation
  output logic              q_push,
  input  logic              q_ready,
  output cgbc_pkg::item_t   q_item
);

  logic            held;
  cgbc_pkg::item_t item;
  cgbc_pkg::item_t item_next;

  assign s_tready = !held || q_ready;
  assign q_push   = held && q_ready;
  assign q_item   = item;

  always_comb begin
    item_next.data = s_tdata;
    // tag codes C1..C4 carry the tag number in their low bits
    item_next.tag  = s_tdata[cgbc_pkg::TAG_W-1:0];
    if (s_tuser) begin
      item_next.kind = cgbc_pkg::KIND_DATA;
    end else if (s_tdata == cgbc_pkg::CMD_NAME) begin
      item_next.kind = cgbc_pkg::KIND_NAME;
    end else if (s_tdata == cgbc_pkg::CMD_STOP) begin
      item_next.kind = cgbc_pkg::KIND_STOP;
    end else if (s_tdata == cgbc_pkg::CMD_START) begin
      item_next.kind = cgbc_pkg::KIND_START;
    end else if (s_tdata >= cgbc_pkg::CMD_TAG_LO && s_tdata <= cgbc_pkg::CMD_TAG_HI) begin
      item_next.kind = cgbc_pkg::KIND_TAG;
    end else begin
      item_next.kind = cgbc_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (q_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

// File: rtl/cgbc_queue.sv
// ----------------------------------------------------------------------------
// cgbc_queue
// short fifo of decoded items between front and back
// ----------------------------------------------------------------------------
`include "command_gated_block_capture_unit_defines.svh"

module cgbc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  cgbc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output cgbc_pkg::item_t pop_item
);

  cgbc_pkg::item_t                   entry [cgbc_pkg::QUEUE_DEPTH];
  logic [cgbc_pkg::QPTR_W-1:0]       wr_ptr;
  logic [cgbc_pkg::QPTR_W-1:0]       rd_ptr;
  logic [cgbc_pkg::QCNT_W-1:0]       count;

  assign push_ready = count != cgbc_pkg::QCNT_W'(cgbc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  `CGBC_ASSERT_IMPL(a_no_overflow, clk, rst, push, push_ready)
  `CGBC_ASSERT_IMPL(a_no_underflow, clk, rst, pop, pop_valid)
  `CGBC_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// File: rtl/cgbc_back.sv
// ----------------------------------------------------------------------------
// cgbc_back
// execution stage: keeps capture state, forms one result per item
// ----------------------------------------------------------------------------
`include "command_gated_block_capture_unit_defines.svh"

module cgbc_back #(
  parameter int BLOCK_COUNT = 20,
  parameter int BLOCK_BYTES = 512,
  parameter int NAME_LEN    = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [cgbc_pkg::PAYLOAD_W-1:0]    cfg_data,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  cgbc_pkg::item_t                   q_item,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output cgbc_pkg::result_t                 m_tdata
);

  localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int YW = $clog2(BLOCK_BYTES);
  localparam int NW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam int CW = ($clog2(BLOCK_BYTES + 1) > cgbc_pkg::PAYLOAD_W) ?
                      $clog2(BLOCK_BYTES + 1) : cgbc_pkg::PAYLOAD_W;

  logic [cgbc_pkg::PAYLOAD_W-1:0] payload_bytes;
  logic                           listening, listening_next;
  logic                           capturing, capturing_next;
  logic [BW-1:0]                  block_pos, block_pos_next;
  logic [YW-1:0]                  byte_pos, byte_pos_next;
  logic [NW-1:0]                  name_pos, name_pos_next;

  logic [CW-1:0]                  eff_payload;
  logic [CW-1:0]                  byte_inc;
  logic [BW:0]                    block_inc;
  logic [NW:0]                    name_inc;
  logic [31:0]                    addr_full;
  cgbc_pkg::result_t              res;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // zero counts as one, anything beyond the block size is clamped
  always_comb begin
    if (payload_bytes == '0) begin
      eff_payload = CW'(1);
    end else if (CW'(payload_bytes) > CW'(BLOCK_BYTES)) begin
      eff_payload = CW'(BLOCK_BYTES);
    end else begin
      eff_payload = CW'(payload_bytes);
    end
  end

  assign byte_inc  = CW'(byte_pos) + CW'(1);
  assign block_inc = {1'b0, block_pos} + 1'b1;
  assign name_inc  = {1'b0, name_pos} + 1'b1;
  assign addr_full = 32'(block_pos) * 32'(BLOCK_BYTES) + 32'(byte_pos);

  always_comb begin
    res            = '0;
    listening_next = listening;
    capturing_next = capturing;
    block_pos_next = block_pos;
    byte_pos_next  = byte_pos;
    name_pos_next  = name_pos;
    if (q_item.kind == cgbc_pkg::KIND_DATA) begin
      if (listening) begin
        res.mem_write   = 1'b1;
        res.mem_address = addr_full[cgbc_pkg::ADDR_W-1:0];
        res.out_byte    = q_item.data;
        if (byte_inc >= eff_payload) begin
          res.block_ready = 1'b1;
          res.ready_block = cgbc_pkg::RBLK_W'(block_pos);
          byte_pos_next   = '0;
          if (32'(block_inc) >= BLOCK_COUNT) begin
            block_pos_next = '0;
          end else begin
            block_pos_next = BW'(block_inc);
          end
        end else begin
          byte_pos_next = YW'(byte_inc);
        end
      end
    end else if (capturing) begin
      // every command byte goes to the name store, the terminating zero too
      res.name_write = 1'b1;
      res.name_index = cgbc_pkg::NIDX_W'(name_pos);
      res.out_byte   = q_item.data;
      if (q_item.data == cgbc_pkg::NAME_END) begin
        res.name_done  = 1'b1;
        name_pos_next  = '0;
        capturing_next = 1'b0;
      end else if (32'(name_inc) >= NAME_LEN) begin
        name_pos_next = '0;
      end else begin
        name_pos_next = NW'(name_inc);
      end
    end else begin
      unique case (q_item.kind)
        cgbc_pkg::KIND_NAME: begin
          capturing_next = 1'b1;
        end
        cgbc_pkg::KIND_STOP: begin
          res.stop_event = 1'b1;
          listening_next = 1'b0;
        end
        cgbc_pkg::KIND_START: begin
          res.start_event = 1'b1;
          listening_next  = 1'b1;
          block_pos_next  = '0;
          byte_pos_next   = '0;
        end
        cgbc_pkg::KIND_TAG: begin
          res.tag_code = q_item.tag;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= cgbc_pkg::PAYLOAD_RESET;
    end else if (cfg_valid) begin
      payload_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listening <= 1'b0;
      capturing <= 1'b0;
      block_pos <= '0;
      byte_pos  <= '0;
      name_pos  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        listening <= listening_next;
        capturing <= capturing_next;
        block_pos <= block_pos_next;
        byte_pos  <= byte_pos_next;
        name_pos  <= name_pos_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= res;
    end
  end

  `CGBC_ASSERT_IMPL(a_ready_needs_write, clk, rst, m_tvalid && m_tdata.block_ready, m_tdata.mem_write)
  `CGBC_ASSERT_IMPL(a_one_store, clk, rst, m_tvalid, !(m_tdata.mem_write && m_tdata.name_write))
  `CGBC_ASSERT_NEXT(a_done_ends_capture, clk, rst, q_pop && capturing && q_item.kind != cgbc_pkg::KIND_DATA && q_item.data == cgbc_pkg::NAME_END, !capturing && name_pos == '0)

endmodule

// File: rtl/command_gated_block_capture_unit.sv
// ----------------------------------------------------------------------------
// command_gated_block_capture_unit
// command gated byte capture into a ring of fixed size blocks
// ----------------------------------------------------------------------------
// Takes one byte per clock (tuser 0 = command byte, 1 = data byte) and gives
// exactly one result per byte, also one per clock; both rates hold only while
// the output is not stalled. A byte passes an input register, a two entry
// queue and the result register before its result appears; the position
// update loop in the back stage sets the rate. Data bytes are stored only
// while listening (after 0xD3, until 0xE2); 0xF3 opens a name capture ending
// on a zero byte; 0xC1..0xC4 report tags. payload_bytes may be written only
// while the unit is idle.
module command_gated_block_capture_unit #(
  parameter int BLOCK_COUNT = 20,
  parameter int BLOCK_BYTES = 512,
  parameter int NAME_LEN    = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // byte_in
  input  logic        s_tuser,    // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  // mem_write, mem_address, out_byte, block_ready, ready_block, name_write,
  // name_index, name_done, start_event, stop_event, tag_code
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data    // payload_bytes
);

  logic              q_push;
  logic              q_ready;
  cgbc_pkg::item_t   front_item;
  logic              q_valid;
  logic              q_pop;
  cgbc_pkg::item_t   back_item;
  cgbc_pkg::result_t result;

  assign cfg_ready = 1'b1;
  assign m_tdata   = result;

  cgbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_item   (front_item)
  );

  cgbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (back_item)
  );

  cgbc_back #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NAME_LEN    (NAME_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (back_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (result)
  );

endmodule

// File: bench/tb_command_gated_block_capture_unit.sv
// ----------------------------------------------------------------------------
// tb_command_gated_block_capture_unit
// self-checking bench for the command gated block capture unit
// ----------------------------------------------------------------------------
// Drives command and data bytes with random gaps and output stalls. An
// in-bench predictor keeps its own copy of the listening and name capture
// state and of the block ring position, and expects one result per byte
// transfer. Every result is compared field by field, in order. The block
// payload size is changed between phases, while the unit is idle.
module tb_command_gated_block_capture_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_COUNT = 20;
  localparam int BLOCK_BYTES = 512;
  localparam int NAME_LEN    = 10;

  // source selector on tuser
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic       op;
    logic [7:0] value;
  } link_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;     // byte_in
  logic        s_tuser = OP_CMD;    // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // mem_write, mem_address, out_byte, block_ready, ready_block, name_write,
  // name_index, name_done, start_event, stop_event, tag_code
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = 10'd0;    // payload_bytes

  command_gated_block_capture_unit #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES),
    .NAME_LEN   (NAME_LEN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // predicted unit state
  logic [9:0]  payload_reg = cgbc_pkg::PAYLOAD_RESET;
  bit          listening;
  bit          capturing_name;
  int unsigned block_pos;
  int unsigned byte_pos;
  int unsigned name_pos;

  link_byte_t        bytes_pending[$];
  cgbc_pkg::result_t results_due[$];
  link_byte_t        next_byte;
  bit          offering;
  bit          send_idle;
  bit          recv_idle;
  int unsigned bytes_queued;
  int unsigned tx_gap;
  int unsigned rx_hold;
  int unsigned results_seen;
  int unsigned fault_count;
  int unsigned cycle_count;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_capture(input logic op, input logic [7:0] b);
    cgbc_pkg::result_t r;
    int unsigned       fill;
    r = '0;
    fill = (payload_reg == 10'd0) ? 1 :
           (payload_reg > BLOCK_BYTES) ? BLOCK_BYTES : int'(payload_reg);
    if (op == OP_DATA) begin
      if (listening) begin
        r.mem_write   = 1'b1;
        r.mem_address = cgbc_pkg::ADDR_W'(block_pos * BLOCK_BYTES + byte_pos);
        r.out_byte    = b;
        byte_pos++;
        if (byte_pos >= fill) begin
          r.block_ready = 1'b1;
          r.ready_block = cgbc_pkg::RBLK_W'(block_pos);
          byte_pos  = 0;
          block_pos = (block_pos + 1 >= BLOCK_COUNT) ? 0 : block_pos + 1;
        end
      end
    end else if (capturing_name) begin
      // every command byte goes to the name store, the ending zero too
      r.name_write = 1'b1;
      r.name_index = cgbc_pkg::NIDX_W'(name_pos);
      r.out_byte   = b;
      name_pos++;
      if (b == cgbc_pkg::NAME_END) begin
        r.name_done    = 1'b1;
        name_pos       = 0;
        capturing_name = 1'b0;
      end
      if (name_pos >= NAME_LEN) name_pos = 0;
    end else if (b == cgbc_pkg::CMD_NAME) begin
      capturing_name = 1'b1;
    end else if (b == cgbc_pkg::CMD_STOP) begin
      r.stop_event = 1'b1;
      listening    = 1'b0;
    end else if (b == cgbc_pkg::CMD_START) begin
      r.start_event = 1'b1;
      listening     = 1'b1;
      block_pos     = 0;
      byte_pos      = 0;
    end else if (b >= cgbc_pkg::CMD_TAG_LO && b <= cgbc_pkg::CMD_TAG_HI) begin
      r.tag_code = cgbc_pkg::TAG_W'(b - cgbc_pkg::CMD_TAG_LO + 8'd1);
    end
    results_due.push_back(r);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("result %0d: %s expected 0x%0h got 0x%0h", results_seen, field, want, got);
    end
  endfunction

  function automatic void check_result(input cgbc_pkg::result_t got);
    cgbc_pkg::result_t want;
    if (results_due.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("result %0d: nothing expected, got 0x%010h", results_seen, got);
      return;
    end
    want = results_due.pop_front();
    check_field("mem_write",   32'(want.mem_write),   32'(got.mem_write));
    check_field("mem_address", 32'(want.mem_address), 32'(got.mem_address));
    check_field("out_byte",    32'(want.out_byte),    32'(got.out_byte));
    check_field("block_ready", 32'(want.block_ready), 32'(got.block_ready));
    check_field("ready_block", 32'(want.ready_block), 32'(got.ready_block));
    check_field("name_write",  32'(want.name_write),  32'(got.name_write));
    check_field("name_index",  32'(want.name_index),  32'(got.name_index));
    check_field("name_done",   32'(want.name_done),   32'(got.name_done));
    check_field("start_event", 32'(want.start_event), 32'(got.start_event));
    check_field("stop_event",  32'(want.stop_event),  32'(got.stop_event));
    check_field("tag_code",    32'(want.tag_code),    32'(got.tag_code));
  endfunction

  // driver: one byte on the slave side at a time, held until the transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
      tx_gap   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_capture(s_tuser, s_tdata);
        offering = 1'b0;
        if (send_idle && $urandom_range(0, 99) < 12) tx_gap = $urandom_range(1, 10);
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (bytes_pending.size() > 0) begin
          next_byte = bytes_pending.pop_front();
          offering  = 1'b1;
          s_tvalid <= 1'b1;
          s_tuser  <= next_byte.op;
          s_tdata  <= next_byte.value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and stalls the master side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(cgbc_pkg::result_t'(m_tdata));
        results_seen++;
        // long hold-offs, so the unit backs up and stalls its input
        if (results_seen == 500 || results_seen == 800) rx_hold = LONG_HOLD;
        else if (recv_idle && $urandom_range(0, 99) < 12) rx_hold = $urandom_range(1, 10);
      end else if (rx_hold == 0 && recv_idle && $urandom_range(0, 99) < 5) begin
        rx_hold = $urandom_range(1, 10);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("command_gated_block_capture_unit test failed");
      $finish;
    end
  end

  function automatic void queue_byte(input logic op, input logic [7:0] value);
    link_byte_t item;
    item.op    = op;
    item.value = value;
    bytes_pending.push_back(item);
    bytes_queued++;
  endfunction

  task automatic set_payload(input logic [9:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    payload_reg = value;
  endtask

  // wait until every byte is taken and every result is back
  task automatic drain();
    while (bytes_pending.size() != 0 || offering || results_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // mostly well formed command sequences and data runs, some noise
  task automatic gen_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_byte(OP_CMD, cgbc_pkg::CMD_START);
      end else if (pick < 14) begin
        queue_byte(OP_CMD, cgbc_pkg::CMD_STOP);
      end else if (pick < 22) begin
        queue_byte(OP_CMD, 8'(cgbc_pkg::CMD_TAG_LO + $urandom_range(0, 3)));
      end else if (pick < 30) begin
        // name of random length, longer ones wrap the index
        queue_byte(OP_CMD, cgbc_pkg::CMD_NAME);
        len = $urandom_range(0, 14);
        repeat (len) queue_byte(OP_CMD, 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 4) != 0) queue_byte(OP_CMD, cgbc_pkg::NAME_END);
      end else if (pick < 36) begin
        queue_byte(OP_CMD, 8'($urandom));
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) queue_byte(OP_DATA, 8'($urandom));
      end
    end
  endtask

  task automatic traffic_phase(input logic [9:0] payload, input int unsigned count,
                               input bit idle);
    set_payload(payload);
    send_idle = idle;
    recv_idle = idle;
    gen_traffic(count);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_payload(10'd2);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    // data before any start is dropped
    queue_byte(OP_DATA, 8'hFF);
    queue_byte(OP_DATA, 8'h00);
    // unknown commands and all tags
    queue_byte(OP_CMD, 8'h00);
    queue_byte(OP_CMD, 8'hFF);
    queue_byte(OP_CMD, cgbc_pkg::CMD_TAG_LO);
    queue_byte(OP_CMD, 8'(cgbc_pkg::CMD_TAG_LO + 8'd1));
    queue_byte(OP_CMD, 8'(cgbc_pkg::CMD_TAG_LO + 8'd2));
    queue_byte(OP_CMD, cgbc_pkg::CMD_TAG_HI);
    queue_byte(OP_CMD, 8'(cgbc_pkg::CMD_TAG_LO - 8'd1));
    queue_byte(OP_CMD, 8'(cgbc_pkg::CMD_TAG_HI + 8'd1));
    queue_byte(OP_CMD, cgbc_pkg::CMD_START);
    queue_byte(OP_DATA, 8'hFF);
    queue_byte(OP_DATA, 8'h00);
    queue_byte(OP_DATA, 8'hA5);
    // command codes inside a name are stored, not executed
    queue_byte(OP_CMD, cgbc_pkg::CMD_NAME);
    queue_byte(OP_CMD, cgbc_pkg::CMD_NAME);
    queue_byte(OP_CMD, cgbc_pkg::CMD_START);
    queue_byte(OP_CMD, cgbc_pkg::CMD_STOP);
    queue_byte(OP_CMD, 8'hFF);
    queue_byte(OP_CMD, cgbc_pkg::NAME_END);
    queue_byte(OP_DATA, 8'h5A);
    queue_byte(OP_CMD, cgbc_pkg::CMD_STOP);
    queue_byte(OP_DATA, 8'h3C);
    // restart goes back to block 0
    queue_byte(OP_CMD, cgbc_pkg::CMD_START);
    queue_byte(OP_DATA, 8'h81);
    drain();

    traffic_phase(10'd1, 120, 1'b1);
    traffic_phase(10'd0, 80, 1'b1);
    traffic_phase(10'd2, 80, 1'b1);
    traffic_phase(10'd7, 100, 1'b0);

    // oversized payload clamps to a full block
    set_payload(10'd1023);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    queue_byte(OP_CMD, cgbc_pkg::CMD_START);
    repeat (520) queue_byte(OP_DATA, 8'($urandom));
    drain();

    traffic_phase(10'd512, 60, 1'b1);
    traffic_phase(cgbc_pkg::PAYLOAD_RESET, 40, 1'b1);
    traffic_phase(10'($urandom_range(3, 16)), 150, 1'b0);

    fault_count += results_due.size();
    if (fault_count == 0) begin
      $display("command_gated_block_capture_unit test passed");
    end else begin
      $display("command_gated_block_capture_unit test failed");
    end
    $finish;
  end

endmodule
